// File: sv/page_frame_free_list_assert.svh
// Assertion macros used by the checker file of the page frame free list.
`ifndef PAGE_FRAME_FREE_LIST_ASSERT_SVH
`define PAGE_FRAME_FREE_LIST_ASSERT_SVH

// Same-cycle implication, disabled while rst_n is low.
`define PFL_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pfl assertion failed");

// Next-cycle implication, disabled while rst_n is low.
`define PFL_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pfl assertion failed");

`endif

// File: sv/pfl_pkg.sv
// Shared constants, codes and types of the page frame free list.
`timescale 1ns / 1ps

package pfl_pkg;

    localparam int PAGE_SHIFT   = 12;
    localparam int STACK_DEPTH  = 32768;
    localparam int ADDRESS_BITS = 56;
    localparam int PNUM_BITS    = ADDRESS_BITS - PAGE_SHIFT;
    localparam int PTR_BITS     = $clog2(STACK_DEPTH);
    localparam int CNT_BITS     = $clog2(STACK_DEPTH + 1);

    localparam int CFG_IDX_BITS = 1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_KERNEL_END = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MEMORY_TOP = 1'b1;

    localparam logic [1:0] OP_INIT  = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_ALLOC = 2'd2;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_OOM     = 2'd1;
    localparam logic [1:0] STATUS_INVALID = 2'd2;
    localparam logic [1:0] STATUS_FULL    = 2'd3;

    localparam logic [2:0] CMD_NOP      = 3'd0;
    localparam logic [2:0] CMD_INIT     = 3'd1;
    localparam logic [2:0] CMD_FREE     = 3'd2;
    localparam logic [2:0] CMD_BAD_FREE = 3'd3;
    localparam logic [2:0] CMD_ALLOC    = 3'd4;

    typedef struct packed {
        logic [2:0]           kind;
        logic [PNUM_BITS-1:0] pnum;
    } t_cmd;

    typedef struct packed {
        logic [ADDRESS_BITS-1:0] addr;
        logic [1:0]              status;
    } t_result;

    typedef struct packed {
        logic [ADDRESS_BITS-1:0] kernel_end;
        logic [ADDRESS_BITS-1:0] memory_top;
    } t_cfg;

endpackage

// File: sv/page_frame_free_list.sv
// Page frame free list top level: configuration registers, front, back and result queue.
//
// Requests enter through a queue-style port: a word is taken on a rising edge with
// push high and full low. Opcode initialize resets the free set to the pages between
// the rounded-up kernel end and the memory top, free returns one page, allocate hands
// out the most recently freed page, else the highest untouched page.
// Results leave through a second queue-style port: the oldest result is shown while
// empty is low and is taken on a rising edge with pop high. Every request gives one
// result word, in request order.
// Configuration (index 0 kernel end, index 1 memory top) is written through its own
// valid/ready channel, which is always ready; the user must write it only while no
// request is in flight, as the block does not enforce this. Each request is registered
// in the command queue and its result in the result queue; an allocate served from the
// freed-page stack also passes the registered stack read. The back end takes one command
// per cycle while the result queue has room, but none while such an allocate is in its
// read state. The stack is one single-port 32768 x 44 memory.
// Reset empties both queues and leaves no free pages; no clearing pass is needed.
// When the receiver stalls the result queue fills, the back end stops, and full rises
// once the two-word command queue is full.
`timescale 1ns / 1ps

module page_frame_free_list import pfl_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    push,
    output logic                    full,
    input  logic [1:0]              i_opcode,
    input  logic [ADDRESS_BITS-1:0] i_page_address,
    output logic                    empty,
    input  logic                    pop,
    output logic [ADDRESS_BITS-1:0] o_granted_address,
    output logic [1:0]              o_status,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [ADDRESS_BITS-1:0] i_cfg_data
);

    t_cfg       r_cfg;
    logic       cmd_valid;
    logic       cmd_ready;
    t_cmd       cmd;
    logic       res_valid;
    logic       res_room;
    t_result    res;
    t_result    r_res_q [2];
    logic       r_res_wr;
    logic       r_res_rd;
    logic [1:0] r_res_cnt;
    logic [1:0] n_res_cnt;
    logic       res_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_KERNEL_END: r_cfg.kernel_end <= i_cfg_data;
                CFG_MEMORY_TOP: r_cfg.memory_top <= i_cfg_data;
            endcase
        end
    end

    pfl_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .push           (push),
        .full           (full),
        .i_opcode       (i_opcode),
        .i_page_address (i_page_address),
        .o_cmd_valid    (cmd_valid),
        .o_cmd          (cmd),
        .i_cmd_ready    (cmd_ready)
    );

    pfl_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_ready (cmd_ready),
        .i_res_room  (res_room),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // The back end starts a command only with room here, and nothing else writes
    // until that command's result is in, so a write never finds the queue full.
    assign res_room          = (r_res_cnt != 2'd2);
    assign empty             = (r_res_cnt == 2'd0);
    assign res_pop           = pop && !empty;
    assign o_granted_address = r_res_q[r_res_rd].addr;
    assign o_status          = r_res_q[r_res_rd].status;

    always_comb begin
        n_res_cnt = r_res_cnt;
        if (res_valid && !res_pop) begin
            n_res_cnt = r_res_cnt + 2'd1;
        end else if (res_pop && !res_valid) begin
            n_res_cnt = r_res_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_cnt <= 2'd0;
            r_res_wr  <= 1'b0;
            r_res_rd  <= 1'b0;
        end else begin
            r_res_cnt <= n_res_cnt;
            if (res_valid) begin
                r_res_wr <= !r_res_wr;
            end
            if (res_pop) begin
                r_res_rd <= !r_res_rd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_res_q[r_res_wr] <= res;
        end
    end

endmodule

// File: sv/pfl_front.sv
// Front end: accepts requests, checks free addresses and queues classified commands.
`timescale 1ns / 1ps

module pfl_front import pfl_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cfg                    i_cfg,
    input  logic                    push,
    output logic                    full,
    input  logic [1:0]              i_opcode,
    input  logic [ADDRESS_BITS-1:0] i_page_address,
    output logic                    o_cmd_valid,
    output t_cmd                    o_cmd,
    input  logic                    i_cmd_ready
);

    t_cmd       cmd_in;
    logic       bad_addr;
    logic       wr_en;
    logic       rd_en;
    t_cmd       r_q [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;

    assign bad_addr = (i_page_address == '0) ||
                      (i_page_address[PAGE_SHIFT-1:0] != '0) ||
                      (i_page_address < i_cfg.kernel_end) ||
                      (i_page_address >= i_cfg.memory_top);

    always_comb begin
        cmd_in.pnum = i_page_address[ADDRESS_BITS-1:PAGE_SHIFT];
        unique case (i_opcode)
            OP_INIT:  cmd_in.kind = CMD_INIT;
            OP_FREE:  cmd_in.kind = bad_addr ? CMD_BAD_FREE : CMD_FREE;
            OP_ALLOC: cmd_in.kind = CMD_ALLOC;
            default:  cmd_in.kind = CMD_NOP;
        endcase
    end

    assign full        = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rd_ptr];
    assign wr_en       = push && !full;
    assign rd_en       = o_cmd_valid && i_cmd_ready;

    always_comb begin
        n_cnt = r_cnt;
        if (wr_en && !rd_en) begin
            n_cnt = r_cnt + 2'd1;
        end else if (rd_en && !wr_en) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= 2'd0;
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (wr_en) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (rd_en) begin
                r_rd_ptr <= !r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_q[r_wr_ptr] <= cmd_in;
        end
    end

endmodule

// File: sv/pfl_back.sv
// Back end: owns the freed-page stack and the untouched region and executes commands.
`timescale 1ns / 1ps

module pfl_back import pfl_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_cmd_valid,
    input  t_cmd    i_cmd,
    output logic    o_cmd_ready,
    input  logic    i_res_room,
    output logic    o_res_valid,
    output t_result o_res
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_READ = 1'b1;

    logic                 r_state;
    logic                 n_state;
    logic [CNT_BITS-1:0]  r_count;
    logic [CNT_BITS-1:0]  n_count;
    logic [PNUM_BITS-1:0] r_next;
    logic [PNUM_BITS-1:0] n_next;
    logic [PNUM_BITS-1:0] r_base;
    logic [PNUM_BITS-1:0] n_base;

    logic [PNUM_BITS-1:0] r_stack [STACK_DEPTH];
    logic [PNUM_BITS-1:0] r_rd_data;
    logic                 mem_we;
    logic                 mem_re;
    logic [PTR_BITS-1:0]  mem_addr;

    logic                 take;
    logic [PNUM_BITS:0]   init_base;
    logic [PNUM_BITS-1:0] init_top;
    logic [CNT_BITS-1:0]  count_m1;
    logic [PNUM_BITS-1:0] next_m1;

    assign o_cmd_ready = (r_state == ST_IDLE) && i_res_room;
    assign take        = i_cmd_valid && o_cmd_ready;

    // First managed page is the kernel end rounded up; the carry bit is kept
    // so that a round-up past the top of the address space compares correctly.
    assign init_base = {1'b0, i_cfg.kernel_end[ADDRESS_BITS-1:PAGE_SHIFT]} +
                       (PNUM_BITS+1)'(|i_cfg.kernel_end[PAGE_SHIFT-1:0]);
    assign init_top  = i_cfg.memory_top[ADDRESS_BITS-1:PAGE_SHIFT];
    assign count_m1  = r_count - 1'b1;
    assign next_m1   = r_next - 1'b1;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_next      = r_next;
        n_base      = r_base;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_addr    = r_count[PTR_BITS-1:0];
        o_res_valid = 1'b0;
        o_res       = '{addr: '0, status: STATUS_OK};
        if (r_state == ST_READ) begin
            o_res_valid = 1'b1;
            o_res.addr  = {r_rd_data, {PAGE_SHIFT{1'b0}}};
            n_state     = ST_IDLE;
        end else if (take) begin
            o_res_valid = 1'b1;
            unique case (i_cmd.kind)
                CMD_INIT: begin
                    n_count = '0;
                    n_base  = init_base[PNUM_BITS-1:0];
                    n_next  = (init_base < {1'b0, init_top}) ? init_top
                                                              : init_base[PNUM_BITS-1:0];
                end
                CMD_FREE: begin
                    if (r_count == CNT_BITS'(STACK_DEPTH)) begin
                        o_res.status = STATUS_FULL;
                    end else begin
                        mem_we  = 1'b1;
                        n_count = r_count + 1'b1;
                    end
                end
                CMD_BAD_FREE: begin
                    o_res.status = STATUS_INVALID;
                end
                CMD_ALLOC: begin
                    if (r_count != '0) begin
                        // Stack data comes back registered; the result goes out next cycle.
                        o_res_valid = 1'b0;
                        mem_re      = 1'b1;
                        mem_addr    = count_m1[PTR_BITS-1:0];
                        n_count     = count_m1;
                        n_state     = ST_READ;
                    end else if (r_next > r_base) begin
                        n_next     = next_m1;
                        o_res.addr = {next_m1, {PAGE_SHIFT{1'b0}}};
                    end else begin
                        o_res.status = STATUS_OOM;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_next  <= '0;
            r_base  <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_next  <= n_next;
            r_base  <= n_base;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_stack[mem_addr] <= i_cmd.pnum;
        end
        if (mem_re) begin
            r_rd_data <= r_stack[mem_addr];
        end
    end

endmodule

// File: sv/pfl_checker.sv
// Port-level checker of the page frame free list and its bind statement.
`timescale 1ns / 1ps
`include "page_frame_free_list_assert.svh"

module pfl_checker import pfl_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    full,
    input logic                    empty,
    input logic                    pop,
    input logic [ADDRESS_BITS-1:0] o_granted_address,
    input logic [1:0]              o_status
);

    // Reset leaves both queues empty.
    `PFL_ASSERT_NXT(a_reset_clears, i_clk, 1'b1, !i_rst_n, empty && !full)

    // A failed result never carries an address (nor, by design, does a non-allocate one; not asserted).
    `PFL_ASSERT_IMP(a_fail_no_addr, i_clk, i_rst_n, !empty && (o_status != STATUS_OK), o_granted_address == '0)

    // A granted address is always a whole page.
    `PFL_ASSERT_IMP(a_grant_aligned, i_clk, i_rst_n, !empty && (o_granted_address != '0), o_granted_address[PAGE_SHIFT-1:0] == '0)

    // A result that is not taken stays on the ports unchanged.
    `PFL_ASSERT_NXT(a_stall_holds, i_clk, i_rst_n, !empty && !pop, !empty && $stable(o_granted_address) && $stable(o_status))

endmodule

bind page_frame_free_list pfl_checker u_pfl_checker (.*);
